// ===== hw/rtl/rmvmm_pkg.sv =====
package rmvmm_pkg;

    localparam int SAMPLE_WIDTH  = 32;
    localparam int FRACTION_BITS = 16;
    localparam int COUNT_WIDTH   = 32;
    localparam int SUM_WIDTH     = 64;
    localparam int DIFF_WIDTH    = SAMPLE_WIDTH + 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = 1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = {COUNT_WIDTH{1'b1}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic [31:0]            mean_value;
        logic [SUM_WIDTH-1:0]   sample_variance;
        logic                   variance_valid;
        logic [31:0]            minimum;
        logic [31:0]            maximum;
        logic                   saturated;
    } t_result;

    typedef struct packed {
        logic                          dropped;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } t_request;

endpackage

// ===== hw/rtl/rmvmm_front.sv =====
module rmvmm_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [31:0]                      i_sample,
    input  logic                             i_deq,
    output logic                             o_avail,
    output rmvmm_pkg::t_request              o_req
);

    rmvmm_pkg::t_request r_mem [rmvmm_pkg::QUEUE_DEPTH];
    logic [rmvmm_pkg::QUEUE_AW-1:0] r_wp, r_rp;
    logic [rmvmm_pkg::QUEUE_AW:0]   r_cnt;
    logic [rmvmm_pkg::COUNT_WIDTH-1:0] r_taken;
    logic                           w_acc;
    rmvmm_pkg::t_request            w_new;

    assign o_full  = (r_cnt == (rmvmm_pkg::QUEUE_AW+1)'(rmvmm_pkg::QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign w_acc   = i_push && !o_full;
    assign o_req   = r_mem[r_rp];

    // classify: count of accepted samples decides which are dropped
    always_comb begin
        w_new.sample  = i_sample[rmvmm_pkg::SAMPLE_WIDTH-1:0];
        w_new.dropped = (r_taken == rmvmm_pkg::COUNT_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_taken <= '0;
        end else begin
            if (w_acc) begin
                r_wp <= r_wp + 1'b1;
                if (!w_new.dropped) begin
                    r_taken <= r_taken + 1'b1;
                end
            end
            if (i_deq && o_avail) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (rmvmm_pkg::QUEUE_AW+1)'(w_acc)
                           - (rmvmm_pkg::QUEUE_AW+1)'(i_deq && o_avail);
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (rmvmm_pkg::QUEUE_AW+1)'(rmvmm_pkg::QUEUE_DEPTH))
        else $error("queue overflow");
    a_deq_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_avail && !i_deq && !w_acc) |=> $stable(r_cnt))
        else $error("queue count moved");
    a_taken_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_taken == rmvmm_pkg::COUNT_FULL) |=> (r_taken == rmvmm_pkg::COUNT_FULL))
        else $error("count wrapped");

endmodule

// ===== hw/rtl/rmvmm_divider.sv =====
module rmvmm_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rmvmm_pkg::SUM_WIDTH-1:0]  i_num,
    input  logic [rmvmm_pkg::COUNT_WIDTH-1:0] i_den,
    output logic                             o_done,
    output logic [rmvmm_pkg::SUM_WIDTH-1:0]  o_quot
);

    localparam int SW = rmvmm_pkg::SUM_WIDTH;
    localparam int CW = rmvmm_pkg::COUNT_WIDTH;
    localparam int IW = $clog2(SW + 1);

    logic [SW-1:0] r_q;
    logic [CW:0]   r_rem;
    logic [CW-1:0] r_den;
    logic [IW-1:0] r_i;
    logic          r_busy;
    logic [CW:0]   w_sh;
    logic [CW:0]   w_sub;

    assign w_sh  = {r_rem[CW-1:0], r_q[SW-1]};
    assign w_sub = w_sh - {1'b0, r_den};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_i    <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= IW'(SW);
            end else if (r_busy) begin
                r_i <= r_i - 1'b1;
                if (r_i == IW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_sub[CW]) begin
                r_rem <= w_sub;
                r_q   <= {r_q[SW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[SW-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== hw/rtl/rmvmm_back.sv =====
module rmvmm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_avail,
    input  rmvmm_pkg::t_request  i_req,
    output logic                 o_deq,
    output logic                 o_res_valid,
    output rmvmm_pkg::t_result   o_res,
    input  logic                 i_res_take
);

    localparam int SW = rmvmm_pkg::SAMPLE_WIDTH;
    localparam int DW = rmvmm_pkg::DIFF_WIDTH;
    localparam int CW = rmvmm_pkg::COUNT_WIDTH;
    localparam int UW = rmvmm_pkg::SUM_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MDIV = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_VDIV = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]              r_st;
    logic [CW-1:0]           r_count;
    logic signed [SW-1:0]    r_mean, r_lo, r_hi, r_x;
    logic [UW-1:0]           r_sum;
    logic signed [DW-1:0]    r_delta;
    logic                    r_neg, r_sat;
    logic [2*DW-1:0]         r_prod;
    logic                    r_res_valid;
    rmvmm_pkg::t_result      r_res;

    logic                    w_dstart, w_ddone;
    logic [UW-1:0]           w_num, w_quot;
    logic [CW-1:0]           w_den;
    logic [DW-1:0]           w_dmag;
    logic signed [DW-1:0]    w_after, w_qs, w_newmean;
    logic [DW-1:0]           w_amag;
    logic [UW-1:0]           w_add;
    logic [UW:0]             w_sum1;
    logic signed [DW-1:0]    w_din;
    logic [DW-1:0]           w_dimag;
    logic [UW-1:0]           w_newsum;
    logic                    w_out_go;

    assign w_dmag = r_delta[DW-1] ? DW'(-r_delta) : DW'(r_delta);
    assign w_qs   = r_neg ? -DW'(w_quot[DW-1:0]) : DW'(w_quot[DW-1:0]);
    assign w_newmean = DW'(r_mean) + w_qs;
    assign w_after = DW'(r_x) - DW'(r_mean);
    assign w_amag  = w_after[DW-1] ? DW'(-w_after) : DW'(w_after);
    assign w_add   = UW'(r_prod >> rmvmm_pkg::FRACTION_BITS);
    assign w_sum1  = {1'b0, r_sum} + {1'b0, w_add};
    // dropped request leaves the sum alone; overflow clips to all ones
    assign w_newsum = r_sat ? r_sum : (w_sum1[UW] ? {UW{1'b1}} : w_sum1[UW-1:0]);

    assign w_din   = DW'(i_req.sample) - DW'(r_mean);
    assign w_dimag = w_din[DW-1] ? DW'(-w_din) : DW'(w_din);

    assign w_num = (r_st == S_IDLE) ? UW'(w_dimag) : w_newsum;
    assign w_den = (r_st == S_IDLE) ? r_count + 1'b1 : r_count - 1'b1;

    rmvmm_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_num), .i_den(w_den), .o_done(w_ddone), .o_quot(w_quot)
    );

    assign o_res_valid = r_res_valid;
    assign o_res = r_res;
    assign o_deq = (r_st == S_IDLE) && i_avail;
    assign w_out_go = (r_st == S_OUT) && (!r_res_valid || i_res_take);
    assign w_dstart = (o_deq && !i_req.dropped) ||
                      (r_st == S_ACC && r_count >= CW'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_count     <= '0;
            r_mean      <= '0;
            r_sum       <= '0;
            r_lo        <= rmvmm_pkg::SAMPLE_MAX;
            r_hi        <= rmvmm_pkg::SAMPLE_MIN;
            r_res_valid <= 1'b0;
        end else begin
            if (w_out_go) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && i_res_take) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (o_deq) begin
                        r_x     <= i_req.sample;
                        r_delta <= w_din;
                        r_neg   <= w_din[DW-1];
                        if (i_req.dropped) begin
                            r_sat <= 1'b1;
                            r_st  <= S_ACC;
                        end else begin
                            r_sat   <= 1'b0;
                            r_count <= r_count + 1'b1;
                            if (i_req.sample < r_lo) r_lo <= i_req.sample;
                            if (i_req.sample > r_hi) r_hi <= i_req.sample;
                            r_st <= S_MDIV;
                        end
                    end
                end
                S_MDIV: begin
                    if (w_ddone) begin
                        r_mean <= SW'(w_newmean);
                        r_st   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= w_dmag * w_amag;
                    r_st   <= S_ACC;
                end
                S_ACC: begin
                    r_sum <= w_newsum;
                    if (!r_sat && w_sum1[UW]) begin
                        r_sat <= 1'b1;
                    end
                    r_st <= (r_count >= CW'(2)) ? S_VDIV : S_OUT;
                end
                S_VDIV: begin
                    if (w_ddone) r_st <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_go) begin
                        r_res.count           <= r_count;
                        r_res.mean_value      <= 32'(r_mean);
                        r_res.sample_variance <= (r_count >= CW'(2)) ? w_quot : '0;
                        r_res.variance_valid  <= (r_count >= CW'(2));
                        r_res.minimum         <= 32'(r_lo);
                        r_res.maximum         <= 32'(r_hi);
                        r_res.saturated       <= r_sat;
                        r_st                  <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_res_take) |=> (r_res_valid && $stable(r_res)))
        else $error("held result changed");
    a_lohi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_lo <= r_hi)) else $error("min above max");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |=> r_res_valid) else $error("result lost");

endmodule

// ===== hw/rtl/running_mean_variance_min_max.sv =====
// channel | handshake        | ports
// input   | push / full      | i_sample
// result  | empty / pop      | o_count o_mean_value o_sample_variance o_variance_valid
//         |                  | o_minimum o_maximum o_saturated
// Each sample takes two 64-step passes of the shared restoring divider (mean step,
// variance) plus control states; a dropped sample takes the variance pass only.
// The first sample has no variance divide. Synchronous active-low reset clears all stats.
// A two-entry queue takes requests while the back end works; a held result stalls the back
// end only once the next result is ready.
module running_mean_variance_min_max (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_sample,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_count,
    output logic [31:0] o_mean_value,
    output logic [63:0] o_sample_variance,
    output logic        o_variance_valid,
    output logic [31:0] o_minimum,
    output logic [31:0] o_maximum,
    output logic        o_saturated
);

    logic                w_avail, w_deq, w_rv;
    rmvmm_pkg::t_request w_req;
    rmvmm_pkg::t_result  w_res;

    rmvmm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_sample(i_sample), .i_deq(w_deq), .o_avail(w_avail), .o_req(w_req)
    );

    rmvmm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(w_avail), .i_req(w_req),
        .o_deq(w_deq), .o_res_valid(w_rv), .o_res(w_res), .i_res_take(pop)
    );

    assign empty             = !w_rv;
    assign o_count           = w_res.count;
    assign o_mean_value      = w_res.mean_value;
    assign o_sample_variance = w_res.sample_variance;
    assign o_variance_valid  = w_res.variance_valid;
    assign o_minimum         = w_res.minimum;
    assign o_maximum         = w_res.maximum;
    assign o_saturated       = w_res.saturated;

endmodule
